// ===== sv/gfpd_pkg.sv =====
// Shared constants, result and request codes, and the cell control bundle
// for the GF(2^m) polynomial long divider. Depends on nothing else.
package gfpd_pkg;

    // Default sizing of the divider.
    localparam int MAX_DEGREE_DEF  = 32;
    localparam int SYMBOL_BITS_DEF = 8;

    // Fixed port widths.
    localparam int COEF_W  = 8;
    localparam int VALUE_W = 8;
    localparam int KIND_W  = 2;
    localparam int POLY_W  = 9;

    localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;

    // Request type codes.
    localparam logic REQ_DIVISOR  = 1'b0;
    localparam logic REQ_DIVIDEND = 1'b1;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_QUOT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Operation broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic clear;    // start of a divisor load: wipe divisor and window
        logic wr;       // write the incoming divisor symbol at the addressed cell
        logic norm;     // scale the stored divisor by the lead inverse
        logic step;     // one long division step on a dividend symbol
        logic shift;    // move the window one place towards cell 0
    } t_cell_ctl;

endpackage

// ===== sv/gf_poly_long_division_top.sv =====
// A result passes through the pending register and then the output register.
// Dividend coefficients are taken one per cycle while the block is idle, the result
// queue has room and no register write is offered; the last one is followed by the
// remainder coefficients, shifted out of the cell chain. A divisor's last coefficient
// starts the inverse iteration, then scaling of the chain; a register write rescales the chain.
// Reset (synchronous, active low): no divisor loaded, field polynomial 0x11D.
module gf_poly_long_division_top import gfpd_pkg::*; #(
    parameter int MAX_DEGREE  = MAX_DEGREE_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [POLY_W-1:0] i_cfg_data,
    // Input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [COEF_W-1:0] i_coef,
    input  logic              i_last,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [KIND_W-1:0]  o_kind,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_final_res
);

    localparam int STORE_DEPTH = MAX_DEGREE + 1;
    localparam int LEN_W       = $clog2(MAX_DEGREE + 3);
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
    localparam int ICNT_W      = $clog2(SYMBOL_BITS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INV   = 2'd1;
    localparam logic [1:0] ST_NORM  = 2'd2;
    localparam logic [1:0] ST_RDOUT = 2'd3;

    // Control registers
    logic [1:0]        r_state, n_state;
    logic [POLY_W-1:0] r_poly, n_poly;
    logic              r_loading, n_loading;
    logic              r_started, n_started;
    logic              r_bad, n_bad;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [DEG_W-1:0]  r_deg, n_deg;
    logic [DEG_W-1:0]  r_dcnt, n_dcnt;
    logic [DEG_W-1:0]  r_rcnt, n_rcnt;
    logic [ICNT_W-1:0] r_icnt, n_icnt;
    logic              r_p_valid, n_p_valid;
    logic              r_o_valid, n_o_valid;

    // Data registers
    logic [SYMBOL_BITS-1:0] r_lead, n_lead;
    logic [SYMBOL_BITS-1:0] r_sq, n_sq;
    logic [SYMBOL_BITS-1:0] r_inv, n_inv;
    logic [KIND_W-1:0]      r_p_kind, n_p_kind;
    logic [VALUE_W-1:0]     r_p_value, n_p_value;
    logic                   r_p_fin, n_p_fin;
    logic [KIND_W-1:0]      r_o_kind, n_o_kind;
    logic [VALUE_W-1:0]     r_o_value, n_o_value;
    logic                   r_o_fin, n_o_fin;

    // Datapath wires
    logic [SYMBOL_BITS+COEF_W-1:0]  coef_ext;
    logic [SYMBOL_BITS-1:0]         coef_sym;
    logic [SYMBOL_BITS+POLY_W-1:0]  poly_ext;
    logic [SYMBOL_BITS-1:0]         poly_sym;
    logic [SYMBOL_BITS-1:0]         w_chain [MAX_DEGREE+1];
    logic [SYMBOL_BITS-1:0]         w0;
    logic [SYMBOL_BITS-1:0]         q_a, q_prod, sq_in, sq_prod;
    logic [SYMBOL_BITS+VALUE_W-1:0] q_ext, w0_ext;
    logic [VALUE_W-1:0]             q_val, w0_val;
    t_cell_ctl                      cell_ctl;

    // Handshake and divisor bookkeeping
    logic             in_acc, cfg_acc, out_acc, p_move, p_free;
    logic             load_start, started_eff, take, bad_end;
    logic [LEN_W-1:0] len_eff, new_len;
    logic             pend_load;
    logic [KIND_W-1:0]  pend_kind;
    logic [VALUE_W-1:0] pend_val;
    logic               pend_fin;

    // Symbols are SYMBOL_BITS wide inside; ports keep their fixed widths.
    assign coef_ext = {{SYMBOL_BITS{1'b0}}, i_coef};
    assign coef_sym = coef_ext[SYMBOL_BITS-1:0];
    assign poly_ext = {{SYMBOL_BITS{1'b0}}, r_poly};
    assign poly_sym = poly_ext[SYMBOL_BITS-1:0];

    assign w_chain[MAX_DEGREE] = '0;
    assign w0 = w_chain[0];

    // Quotient multiplier; it also forms the running product of the inverse.
    assign q_a = (r_state == ST_INV) ? r_sq : ((r_deg == '0) ? coef_sym : w0);

    gfpd_mul #(
        .SYM_W (SYMBOL_BITS)
    ) u_q_mul (
        .i_a    (q_a),
        .i_b    (r_inv),
        .i_poly (poly_sym),
        .o_p    (q_prod)
    );

    // Squarer for the inverse iteration.
    assign sq_in = (r_icnt == '0) ? r_lead : r_sq;

    gfpd_mul #(
        .SYM_W (SYMBOL_BITS)
    ) u_sq_mul (
        .i_a    (sq_in),
        .i_b    (sq_in),
        .i_poly (poly_sym),
        .o_p    (sq_prod)
    );

    assign q_ext  = {{VALUE_W{1'b0}}, q_prod};
    assign q_val  = q_ext[VALUE_W-1:0];
    assign w0_ext = {{VALUE_W{1'b0}}, w0};
    assign w0_val = w0_ext[VALUE_W-1:0];

    // Chain of division cells.
    for (genvar gi = 0; gi < MAX_DEGREE; gi++) begin : g_cell
        gfpd_cell #(
            .SYM_W (SYMBOL_BITS),
            .LEN_W (LEN_W),
            .DEG_W (DEG_W),
            .IDX   (gi)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_wr_idx (len_eff),
            .i_deg    (r_deg),
            .i_sym    (coef_sym),
            .i_inv    (r_inv),
            .i_w0     (w0),
            .i_poly   (poly_sym),
            .i_w_next (w_chain[gi+1]),
            .o_w      (w_chain[gi])
        );
    end

    // Pending result moves to the output register whenever that is free.
    assign out_acc     = r_o_valid && i_out_ready;
    assign p_move      = r_p_valid && (!r_o_valid || i_out_ready);
    assign p_free      = !r_p_valid || p_move;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE) && p_free && !i_cfg_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // Divisor load: leading zeros are skipped, length counts up past the store.
    assign load_start  = !r_loading;
    assign started_eff = load_start ? 1'b0 : r_started;
    assign len_eff     = load_start ? '0 : r_len;
    assign take        = started_eff || (coef_sym != '0);
    assign new_len     = (take && (len_eff <= LEN_W'(STORE_DEPTH))) ?
                         len_eff + LEN_W'(1) : len_eff;
    assign bad_end     = !take || (new_len > LEN_W'(STORE_DEPTH));

    // Controller.
    always_comb begin
        n_state   = r_state;
        n_poly    = r_poly;
        n_loading = r_loading;
        n_started = r_started;
        n_bad     = r_bad;
        n_len     = r_len;
        n_deg     = r_deg;
        n_dcnt    = r_dcnt;
        n_rcnt    = r_rcnt;
        n_icnt    = r_icnt;
        n_lead    = r_lead;
        n_sq      = r_sq;
        n_inv     = r_inv;
        cell_ctl  = '0;
        pend_load = 1'b0;
        pend_kind = KIND_ERR;
        pend_val  = '0;
        pend_fin  = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (cfg_acc) begin
                    n_poly  = i_cfg_data;
                    n_state = ST_NORM;
                end else if (in_acc && (i_req_type == REQ_DIVISOR)) begin
                    cell_ctl.clear = load_start;
                    cell_ctl.wr    = take && (len_eff < LEN_W'(STORE_DEPTH));
                    if (take && (len_eff == '0)) begin
                        n_lead = coef_sym;
                    end
                    if (load_start) begin
                        n_loading = 1'b1;
                        n_bad     = 1'b1;
                        n_deg     = '0;
                        n_inv     = '0;
                        n_dcnt    = '0;
                    end
                    n_started = take;
                    n_len     = new_len;
                    if (i_last) begin
                        n_loading = 1'b0;
                        if (bad_end) begin
                            n_bad     = 1'b1;
                            pend_load = 1'b1;
                        end else begin
                            n_deg   = DEG_W'(new_len - LEN_W'(1));
                            n_bad   = 1'b0;
                            n_icnt  = '0;
                            n_state = ST_INV;
                        end
                    end
                end else if (in_acc) begin
                    if (r_bad || r_loading) begin
                        // No usable divisor: only the last item answers.
                        pend_load = i_last;
                    end else begin
                        cell_ctl.step = (r_deg != '0);
                        if (r_dcnt < r_deg) begin
                            n_dcnt = r_dcnt + DEG_W'(1);
                        end
                        if ((r_dcnt >= r_deg) || i_last) begin
                            pend_load = 1'b1;
                            pend_kind = KIND_QUOT;
                            pend_val  = q_val;
                            pend_fin  = i_last && (r_deg == '0);
                        end
                        if (i_last) begin
                            n_dcnt = '0;
                            if (r_deg != '0) begin
                                n_rcnt  = r_deg;
                                n_state = ST_RDOUT;
                            end
                        end
                    end
                end
            end

            ST_INV: begin
                // a^(2^m-2) as the product of a^(2^i), one square a cycle.
                n_sq = sq_prod;
                if (r_icnt == '0) begin
                    n_inv = SYMBOL_BITS'(1);
                end else begin
                    n_inv = q_prod;
                end
                if (r_icnt == ICNT_W'(SYMBOL_BITS - 1)) begin
                    n_state = ST_NORM;
                end else begin
                    n_icnt = r_icnt + ICNT_W'(1);
                end
            end

            ST_NORM: begin
                cell_ctl.norm = 1'b1;
                n_state       = ST_IDLE;
            end

            ST_RDOUT: begin
                // Remainder leaves from cell 0; the chain refills with zeros.
                if (p_free) begin
                    pend_load      = 1'b1;
                    pend_kind      = KIND_REM;
                    pend_val       = w0_val;
                    pend_fin       = (r_rcnt == DEG_W'(1));
                    cell_ctl.shift = 1'b1;
                    n_rcnt         = r_rcnt - DEG_W'(1);
                    if (r_rcnt == DEG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Two-entry result queue: pending stage and output register.
    always_comb begin
        n_p_valid = r_p_valid;
        n_p_kind  = r_p_kind;
        n_p_value = r_p_value;
        n_p_fin   = r_p_fin;
        n_o_valid = r_o_valid;
        n_o_kind  = r_o_kind;
        n_o_value = r_o_value;
        n_o_fin   = r_o_fin;
        if (p_move) begin
            n_o_valid = 1'b1;
            n_o_kind  = r_p_kind;
            n_o_value = r_p_value;
            n_o_fin   = r_p_fin;
        end else if (out_acc) begin
            n_o_valid = 1'b0;
        end
        if (pend_load) begin
            n_p_valid = 1'b1;
            n_p_kind  = pend_kind;
            n_p_value = pend_val;
            n_p_fin   = pend_fin;
        end else if (p_move) begin
            n_p_valid = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_poly    <= POLY_RESET;
            r_loading <= 1'b0;
            r_started <= 1'b0;
            r_bad     <= 1'b1;
            r_len     <= '0;
            r_deg     <= '0;
            r_dcnt    <= '0;
            r_rcnt    <= '0;
            r_icnt    <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_poly    <= n_poly;
            r_loading <= n_loading;
            r_started <= n_started;
            r_bad     <= n_bad;
            r_len     <= n_len;
            r_deg     <= n_deg;
            r_dcnt    <= n_dcnt;
            r_rcnt    <= n_rcnt;
            r_icnt    <= n_icnt;
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // Data registers need no reset.
    always_ff @(posedge i_clk) begin
        r_lead    <= n_lead;
        r_sq      <= n_sq;
        r_inv     <= n_inv;
        r_p_kind  <= n_p_kind;
        r_p_value <= n_p_value;
        r_p_fin   <= n_p_fin;
        r_o_kind  <= n_o_kind;
        r_o_value <= n_o_value;
        r_o_fin   <= n_o_fin;
    end

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_value     = r_o_value;
    assign o_final_res = r_o_fin;

endmodule

// ===== sv/gfpd_mul.sv =====
// Combinational GF(2^m) symbol multiplier, reduced by a run-time polynomial.
// Depends on gfpd_pkg for its default symbol width.
module gfpd_mul import gfpd_pkg::*; #(
    parameter int SYM_W = SYMBOL_BITS_DEF
) (
    input  logic [SYM_W-1:0] i_a,
    input  logic [SYM_W-1:0] i_b,
    input  logic [SYM_W-1:0] i_poly,
    output logic [SYM_W-1:0] o_p
);

    logic [SYM_W-1:0] acc;

    // Horner form: double and reduce, then add the multiplicand per bit of b.
    always_comb begin
        acc = '0;
        for (int i = SYM_W - 1; i >= 0; i--) begin
            acc = {acc[SYM_W-2:0], 1'b0} ^ (acc[SYM_W-1] ? i_poly : '0);
            if (i_b[i]) begin
                acc = acc ^ i_a;
            end
        end
        o_p = acc;
    end

endmodule

// ===== sv/gfpd_cell.sv =====
// One cell of the division chain: holds one divisor coefficient, its scaled
// copy and one remainder symbol. Depends on gfpd_pkg and gfpd_mul.
module gfpd_cell import gfpd_pkg::*; #(
    parameter int SYM_W = SYMBOL_BITS_DEF,
    parameter int LEN_W = $clog2(MAX_DEGREE_DEF + 3),
    parameter int DEG_W = $clog2(MAX_DEGREE_DEF + 1),
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [LEN_W-1:0] i_wr_idx,
    input  logic [DEG_W-1:0] i_deg,
    input  logic [SYM_W-1:0] i_sym,
    input  logic [SYM_W-1:0] i_inv,
    input  logic [SYM_W-1:0] i_w0,
    input  logic [SYM_W-1:0] i_poly,
    input  logic [SYM_W-1:0] i_w_next,
    output logic [SYM_W-1:0] o_w
);

    logic [SYM_W-1:0] r_div, n_div;
    logic [SYM_W-1:0] r_g, n_g;
    logic [SYM_W-1:0] r_w, n_w;
    logic [SYM_W-1:0] mul_a, mul_b, prod;
    logic             hit, tap;

    // This cell keeps divisor coefficient IDX+1 and remainder symbol IDX.
    assign hit = (i_wr_idx == LEN_W'(IDX + 1));
    assign tap = (i_deg == DEG_W'(IDX + 1));

    // The one multiplier scales the divisor, or forms the step product.
    assign mul_a = i_ctl.norm ? r_div : i_w0;
    assign mul_b = i_ctl.norm ? i_inv : r_g;

    gfpd_mul #(
        .SYM_W (SYM_W)
    ) u_mul (
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_poly (i_poly),
        .o_p    (prod)
    );

    // Next values of the three cell registers.
    always_comb begin
        n_div = r_div;
        n_g   = r_g;
        n_w   = r_w;
        if (i_ctl.clear) begin
            n_div = '0;
            n_w   = '0;
        end
        if (i_ctl.wr && hit) begin
            n_div = i_sym;
        end
        if (i_ctl.norm) begin
            n_g = prod;
        end
        if (i_ctl.step) begin
            n_w = (tap ? i_sym : i_w_next) ^ prod;
        end
        if (i_ctl.shift) begin
            n_w = i_w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        r_g   <= n_g;
        r_w   <= n_w;
    end

    assign o_w = r_w;

endmodule

// ===== tb/sv/gfpd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the GF(2^m) polynomial long divider: it watches the three channels,
// predicts quotient, remainder and error results and compares them in order.
// Depends on gfpd_pkg for port widths, request codes and result kinds.
module gfpd_checker import gfpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [POLY_W-1:0]  i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_req_type,
    input  logic [COEF_W-1:0]  i_coef,
    input  logic               i_last,
    // Output channel
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_final_res,
    // Status towards the testbench top
    output int                 o_mismatches,
    output int                 o_outstanding
);

    localparam int SYM_BITS = SYMBOL_BITS_DEF;
    localparam int DVSR_DEPTH = MAX_DEGREE_DEF + 1;

    typedef logic [COEF_W-1:0] t_sym;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               fin;
    } t_gf_res;

    // Predicted state of the divider.
    logic [POLY_W-1:0] field_poly;
    t_sym              dvsr_coefs [DVSR_DEPTH];
    int                dvsr_len;
    int                dvsr_deg;
    bit                dvsr_started;
    bit                dvsr_bad;
    bit                dvsr_loading;
    t_sym              lead_inv;
    t_sym              rem_window [MAX_DEGREE_DEF];
    int                dvd_seen;

    t_gf_res           awaited_coefs [$];
    int                mismatches = 0;

    // Multiplication by x, reduced by the field polynomial.
    function automatic t_sym gf_times_x(input t_sym a, input logic [POLY_W-1:0] poly);
        logic [POLY_W-1:0] t;
        t = {a, 1'b0};
        if (t[SYM_BITS]) begin
            t = t ^ poly;
        end
        return t[COEF_W-1:0];
    endfunction

    // Shift-and-add product, most significant bit of b first.
    function automatic t_sym gf_product(input t_sym a, input t_sym b,
                                        input logic [POLY_W-1:0] poly);
        t_sym r;
        r = '0;
        for (int k = SYM_BITS - 1; k >= 0; k--) begin
            r = gf_times_x(r, poly);
            if (b[k]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

    // Inverse as a^(2^m - 2), built from the squares a^2, a^4, ...
    function automatic t_sym gf_recip(input t_sym a, input logic [POLY_W-1:0] poly);
        t_sym sq;
        t_sym res;
        sq  = a;
        res = t_sym'(1);
        for (int k = 1; k < SYM_BITS; k++) begin
            sq  = gf_product(sq, sq, poly);
            res = gf_product(res, sq, poly);
        end
        return res;
    endfunction

    function automatic t_gf_res mk_result(input logic [KIND_W-1:0] kind, input t_sym value,
                                          input logic fin);
        t_gf_res r;
        r.kind  = kind;
        r.value = value;
        r.fin   = fin;
        return r;
    endfunction

    // Append one predicted result at the tail of the queue.
    task automatic queue_result(input t_gf_res r);
        awaited_coefs = {awaited_coefs, r};
    endtask

    task automatic drop_dividend();
        foreach (rem_window[k]) begin
            rem_window[k] = '0;
        end
        dvd_seen = 0;
    endtask

    task automatic reset_model();
        field_poly = POLY_RESET;
        foreach (dvsr_coefs[k]) begin
            dvsr_coefs[k] = '0;
        end
        dvsr_len     = 0;
        dvsr_deg     = 0;
        dvsr_started = 1'b0;
        dvsr_bad     = 1'b1;
        dvsr_loading = 1'b0;
        lead_inv     = '0;
        drop_dividend();
        awaited_coefs.delete();
    endtask

    // Advance the predicted divider by one accepted transaction and queue what it yields.
    task automatic divide_coef(input logic req, input t_sym c, input logic lst);
        t_sym q;
        int   d;
        bit   gave_q;
        gave_q = 1'b0;
        if (req == REQ_DIVISOR) begin
            // The first divisor coefficient after a finished load starts afresh.
            if (!dvsr_loading) begin
                dvsr_loading = 1'b1;
                foreach (dvsr_coefs[k]) begin
                    dvsr_coefs[k] = '0;
                end
                dvsr_len     = 0;
                dvsr_started = 1'b0;
                dvsr_bad     = 1'b1;
                dvsr_deg     = 0;
                lead_inv     = '0;
                drop_dividend();
            end
            // Leading zeros are skipped; the count saturates one past the store.
            if (dvsr_started || c != '0) begin
                dvsr_started = 1'b1;
                if (dvsr_len < DVSR_DEPTH) begin
                    dvsr_coefs[dvsr_len] = c;
                end
                if (dvsr_len <= DVSR_DEPTH) begin
                    dvsr_len++;
                end
            end
            if (lst) begin
                dvsr_loading = 1'b0;
                if (!dvsr_started || dvsr_len > DVSR_DEPTH) begin
                    dvsr_bad = 1'b1;
                    queue_result(mk_result(KIND_ERR, '0, 1'b1));
                end else begin
                    dvsr_deg = dvsr_len - 1;
                    lead_inv = gf_recip(dvsr_coefs[0], field_poly);
                    dvsr_bad = 1'b0;
                end
            end
        end else if (dvsr_bad || dvsr_loading) begin
            // No usable divisor: only the end of the dividend is answered, with an error.
            if (lst) begin
                drop_dividend();
                queue_result(mk_result(KIND_ERR, '0, 1'b1));
            end
        end else begin
            d = dvsr_deg;
            if (d == 0) begin
                q = gf_product(c, lead_inv, field_poly);
            end else begin
                q = gf_product(rem_window[0], lead_inv, field_poly);
                for (int k = 0; k + 1 < d; k++) begin
                    rem_window[k] = rem_window[k + 1] ^
                                    gf_product(q, dvsr_coefs[k + 1], field_poly);
                end
                rem_window[d - 1] = c ^ gf_product(q, dvsr_coefs[d], field_poly);
            end
            if (dvd_seen >= d) begin
                queue_result(mk_result(KIND_QUOT, q, lst && d == 0));
                gave_q = 1'b1;
            end else begin
                dvd_seen++;
            end
            // The last coefficient flushes the remainder; a short dividend gets a zero quotient.
            if (lst) begin
                if (!gave_q) begin
                    queue_result(mk_result(KIND_QUOT, '0, d == 0));
                end
                for (int k = 0; k < d; k++) begin
                    queue_result(mk_result(KIND_REM, rem_window[k], k + 1 == d));
                end
                drop_dividend();
            end
        end
    endtask

    // Results are compared before the predictor moves on, so an early result cannot
    // be matched against an expectation created in the same cycle.
    always @(posedge i_clk) begin : monitor
        t_gf_res want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_coefs.size() == 0) begin
                    $error("unexpected result: kind %0d, value 0x%02h, final_res %0b",
                           i_kind, i_value, i_final_res);
                    mismatches++;
                end else begin
                    want = awaited_coefs.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                        mismatches++;
                    end
                    if (i_value !== want.value) begin
                        $error("value: expected 0x%02h, actual 0x%02h", want.value, i_value);
                        mismatches++;
                    end
                    if (i_final_res !== want.fin) begin
                        $error("final_res: expected %0b, actual %0b", want.fin, i_final_res);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                field_poly = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                divide_coef(i_req_type, i_coef, i_last);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited_coefs.size();
    end

endmodule

// ===== tb/sv/tb_gf_poly_long_division_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the GF(2^m) polynomial long divider: drives divisors, dividends
// and field polynomial writes, paces the result side and gives the verdict.
// Depends on gfpd_pkg, gf_poly_long_division_top and gfpd_checker.
module tb_gf_poly_long_division_top;
    import gfpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = SYMBOL_BITS_DEF + 8;
    localparam int RX_HOLD     = 300;
    localparam int PHASE_ITEMS = 48;
    localparam int N_PHASES    = 5;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [POLY_W-1:0]  i_cfg_data  = POLY_RESET;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic               i_req_type  = REQ_DIVISOR;
    logic [COEF_W-1:0]  i_coef      = '0;
    logic               i_last      = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [KIND_W-1:0]  o_kind;
    logic [VALUE_W-1:0] o_value;
    logic               o_final_res;

    int mismatch_count;
    int outstanding;
    int cycle_count  = 0;
    int sent_items   = 0;
    int hold_epoch   = 0;
    int hold_seen    = 0;
    int rx_gap_left  = 0;
    bit rx_no_gaps   = 1'b0;
    bit tx_no_gaps   = 1'b0;

    gf_poly_long_division_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_coef      (i_coef),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_final_res (o_final_res)
    );

    gfpd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_coef        (i_coef),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_kind        (o_kind),
        .i_value       (o_value),
        .i_final_res   (o_final_res),
        .o_mismatches  (mismatch_count),
        .o_outstanding (outstanding)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly no idling, sometimes a few cycles, rarely a long stretch.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Symbols with extra weight on the all-zero and all-one patterns.
    function automatic logic [COEF_W-1:0] rand_sym();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return COEF_W'($urandom_range(0, 255));
    endfunction

    // Result side pacing; a new hold epoch from the stimulus forces a long hold-off.
    always @(posedge i_clk) begin : rx_pace
        int g;
        if (hold_epoch != hold_seen) begin
            hold_seen   <= hold_epoch;
            rx_gap_left <= RX_HOLD;
            i_out_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left <= rx_gap_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            g = (rx_no_gaps || $urandom_range(0, 2) != 0) ? 0 : random_gap();
            if (g > 0) begin
                rx_gap_left <= g - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // One input transaction; valid stays high afterwards unless a gap or a drain follows.
    task automatic send_coef(input logic req, input logic [COEF_W-1:0] c, input logic lst);
        int gap;
        gap = tx_no_gaps ? 0 : random_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_coef     <= c;
        i_last     <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
    endtask

    // A divisor of n_coefs significant coefficients after lead_zeros zeros;
    // n_coefs of zero gives an all-zero divisor.
    task automatic send_divisor(input int n_coefs, input int lead_zeros);
        int total;
        logic [COEF_W-1:0] c;
        total = lead_zeros + n_coefs;
        for (int k = 0; k < total; k++) begin
            if (k < lead_zeros) begin
                c = '0;
            end else if (k == lead_zeros) begin
                c = COEF_W'($urandom_range(1, 255));
            end else begin
                c = rand_sym();
            end
            send_coef(REQ_DIVISOR, c, k == total - 1);
        end
    endtask

    task automatic send_dividend(input int n);
        for (int k = 0; k < n; k++) begin
            send_coef(REQ_DIVIDEND, rand_sym(), k == n - 1);
        end
    endtask

    // Stop offering, wait for every predicted result, then let the block settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_poly(input logic [POLY_W-1:0] poly);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= poly;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int r;
        int s;
        int n;
        int phase_end;
        logic [POLY_W-1:0] poly;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_poly(POLY_RESET);

        // Dividend before any divisor has been loaded: error on its end.
        send_coef(REQ_DIVIDEND, 8'h55, 1'b0);
        send_coef(REQ_DIVIDEND, 8'hAA, 1'b1);
        // All-zero divisor.
        send_coef(REQ_DIVISOR, 8'h00, 1'b0);
        send_coef(REQ_DIVISOR, 8'h00, 1'b1);
        // Degree two divisor behind a leading zero.
        send_coef(REQ_DIVISOR, 8'h00, 1'b0);
        send_coef(REQ_DIVISOR, 8'h03, 1'b0);
        send_coef(REQ_DIVISOR, 8'h01, 1'b0);
        send_coef(REQ_DIVISOR, 8'h02, 1'b1);
        // Short dividend: zero quotient, then the padded remainder.
        send_coef(REQ_DIVIDEND, 8'hFF, 1'b1);
        // Ordinary division with extreme symbols.
        send_coef(REQ_DIVIDEND, 8'h80, 1'b0);
        send_coef(REQ_DIVIDEND, 8'h01, 1'b0);
        send_coef(REQ_DIVIDEND, 8'hFF, 1'b0);
        send_coef(REQ_DIVIDEND, 8'h00, 1'b1);
        // A new divisor in the middle of a dividend discards it; constant divisor.
        send_coef(REQ_DIVIDEND, 8'h12, 1'b0);
        send_coef(REQ_DIVISOR, 8'h07, 1'b1);
        send_coef(REQ_DIVIDEND, 8'h10, 1'b0);
        send_coef(REQ_DIVIDEND, 8'hFE, 1'b1);
        // Dividend while a divisor is still loading, then the load completes.
        send_coef(REQ_DIVISOR, 8'h05, 1'b0);
        send_coef(REQ_DIVIDEND, 8'h03, 1'b1);
        send_coef(REQ_DIVISOR, 8'h09, 1'b1);
        send_coef(REQ_DIVIDEND, 8'h01, 1'b0);
        send_coef(REQ_DIVIDEND, 8'hC3, 1'b1);

        // Random phases, each under its own field polynomial.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: poly = 9'h100;
                1: poly = 9'h11D;
                2: poly = 9'h1FF;
                3: poly = 9'h12B;
                default: poly = POLY_W'($urandom_range(256, 511));
            endcase
            write_poly(poly);
            tx_no_gaps = (phase == 3);
            rx_no_gaps <= (phase == 3);
            phase_end = sent_items + PHASE_ITEMS;

            // Long receiver hold-off against a steady dividend stream fills the block.
            if (phase == 1) begin
                send_divisor(5, 0);
                tx_no_gaps = 1'b1;
                hold_epoch <= hold_epoch + 1;
                send_dividend(120);
                tx_no_gaps = 1'b0;
                phase_end = sent_items + PHASE_ITEMS;
            end

            while (sent_items < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_coef(1'($urandom_range(0, 1)), rand_sym(),
                              $urandom_range(0, 3) == 0);
                end else begin
                    if (r < 35) begin
                        s = $urandom_range(0, 99);
                        if (s < 50) begin
                            n = $urandom_range(1, 4);
                        end else if (s < 80) begin
                            n = $urandom_range(5, 9);
                        end else if (s < 88) begin
                            n = MAX_DEGREE_DEF + 1;
                        end else if (s < 93) begin
                            n = $urandom_range(MAX_DEGREE_DEF + 2, MAX_DEGREE_DEF + 4);
                        end else begin
                            n = 0;
                        end
                        send_divisor(n, (n == 0) ? int'($urandom_range(1, 4))
                                                 : int'($urandom_range(0, 2)));
                    end
                    repeat ($urandom_range(1, 3)) begin
                        send_dividend(($urandom_range(0, 99) < 88)
                                      ? int'($urandom_range(1, 12))
                                      : int'($urandom_range(20, 60)));
                    end
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
